// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define CIST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define CIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cist_pkg.sv -----
`default_nettype none

package cist_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int MODE_W  = 2;
    localparam int TIME_W  = 64;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // flags carried by the search token from cell to cell
    typedef struct packed {
        logic valid;
        logic act_found;
        logic nxt_found;
    } tok_flags_t;

endpackage

`default_nettype wire

// ----- src/cue_interval_search_table_top.sv -----
// append, clear and the unused mode give their item on done in the cycle after they are taken
// a query's token passes the injection register, then every cell register in the chain, then the done register
// throughput: busy stays low outside queries, so those take one item per cycle;
// a query holds busy high until its token leaves the last cell
// results show on done for one cycle and cannot be held off by the receiver
// reset (rst_n low, asynchronous) empties the table and drops any query in flight
`default_nettype none

module cue_interval_search_table_top #(
    parameter int CAPACITY = cist_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [cist_pkg::MODE_W-1:0]         mode,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  cue_start,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  cue_end,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  query_time,
    output logic                                     done,
    output logic                                     active_found,
    output logic [cist_pkg::INDEX_W-1:0]             active_index,
    output logic                                     next_found,
    output logic [cist_pkg::INDEX_W-1:0]             next_index,
    output logic                                     full_error,
    output logic [cist_pkg::COUNT_W-1:0]             entry_count
);

    // index width covers every cell; count width also holds a full table
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // an item is taken when start meets a free block
    logic accept;
    logic accept_query;
    logic append_ok;

    // fill count of the table
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // query control: busy for the whole trip down the chain
    logic                               busy_reg;
    logic                               busy_next;
    logic                               inj_valid_reg;
    logic signed [cist_pkg::TIME_W-1:0] qtime_reg;

    // token links, link 0 feeds the first cell, link CAPACITY leaves the last
    cist_pkg::tok_flags_t               tok_flags [CAPACITY+1];
    logic [IW-1:0]                      tok_act   [CAPACITY+1];
    logic [IW-1:0]                      tok_nxt   [CAPACITY+1];
    logic signed [cist_pkg::TIME_W-1:0] tok_best  [CAPACITY+1];

    logic [CAPACITY-1:0] wr_vec;
    logic [CAPACITY-1:0] occ_vec;

    // result registers
    logic                done_reg;
    logic                done_next;
    logic                act_found_reg;
    logic                act_found_next;
    logic [IW-1:0]       act_idx_reg;
    logic [IW-1:0]       act_idx_next;
    logic                nxt_found_reg;
    logic                nxt_found_next;
    logic [IW-1:0]       nxt_idx_reg;
    logic [IW-1:0]       nxt_idx_next;
    logic                full_reg;
    logic                full_next;
    logic [CW-1:0]       count_out_reg;
    logic [CW-1:0]       count_out_next;

    logic chain_done;

    assign accept       = start && !busy_reg;
    assign accept_query = accept && (mode == cist_pkg::MODE_QUERY);
    assign append_ok    = count_reg < CW'(CAPACITY);
    assign chain_done   = tok_flags[CAPACITY].valid;

    // new fill count for the item being taken
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            unique case (mode)
                cist_pkg::MODE_APPEND:
                begin
                    if (append_ok)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                cist_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // per-cell write strobe and occupancy; the count is frozen during a query
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            wr_vec[i]  = accept && (mode == cist_pkg::MODE_APPEND) && append_ok
                         && (count_reg == CW'(i));
            occ_vec[i] = CW'(i) < count_reg;
        end
    end

    // busy rises with a query and falls as its token leaves the last cell
    always_comb
    begin
        busy_next = busy_reg;
        if (accept_query)
        begin
            busy_next = 1'b1;
        end
        else if (chain_done)
        begin
            busy_next = 1'b0;
        end
    end

    // empty token entering the chain
    assign tok_flags[0] = '{valid: inj_valid_reg, act_found: 1'b0, nxt_found: 1'b0};
    assign tok_act[0]   = '0;
    assign tok_nxt[0]   = '0;
    assign tok_best[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cist_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_vec[g]),
            .wr_start    (cue_start),
            .wr_end      (cue_end),
            .occupied    (occ_vec[g]),
            .qtime       (qtime_reg),
            .flags_in    (tok_flags[g]),
            .act_idx_in  (tok_act[g]),
            .nxt_idx_in  (tok_nxt[g]),
            .best_in     (tok_best[g]),
            .flags_out   (tok_flags[g+1]),
            .act_idx_out (tok_act[g+1]),
            .nxt_idx_out (tok_nxt[g+1]),
            .best_out    (tok_best[g+1])
        );
    end

    // result selection: immediate items for non-queries, chain output for queries
    always_comb
    begin
        done_next      = 1'b0;
        act_found_next = 1'b0;
        act_idx_next   = '0;
        nxt_found_next = 1'b0;
        nxt_idx_next   = '0;
        full_next      = 1'b0;
        count_out_next = count_out_reg;
        if (chain_done)
        begin
            done_next      = 1'b1;
            act_found_next = tok_flags[CAPACITY].act_found;
            act_idx_next   = tok_flags[CAPACITY].act_found ? tok_act[CAPACITY] : '0;
            nxt_found_next = tok_flags[CAPACITY].nxt_found;
            nxt_idx_next   = tok_flags[CAPACITY].nxt_found ? tok_nxt[CAPACITY] : '0;
            count_out_next = count_reg;
        end
        else if (accept && !accept_query)
        begin
            done_next      = 1'b1;
            full_next      = (mode == cist_pkg::MODE_APPEND) && !append_ok;
            count_out_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            inj_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            inj_valid_reg <= accept_query;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_query)
        begin
            qtime_reg <= query_time;
        end
        act_found_reg <= act_found_next;
        act_idx_reg   <= act_idx_next;
        nxt_found_reg <= nxt_found_next;
        nxt_idx_reg   <= nxt_idx_next;
        full_reg      <= full_next;
        count_out_reg <= count_out_next;
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign active_found = act_found_reg;
    assign active_index = cist_pkg::INDEX_W'(act_idx_reg);
    assign next_found   = nxt_found_reg;
    assign next_index   = cist_pkg::INDEX_W'(nxt_idx_reg);
    assign full_error   = full_reg;
    assign entry_count  = cist_pkg::COUNT_W'(count_out_reg);

endmodule

`default_nettype wire

// ----- src/cist_cell.sv -----
`default_nettype none

module cist_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  wr_start,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  wr_end,
    input  wire logic                                occupied,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  qtime,
    input  wire cist_pkg::tok_flags_t                flags_in,
    input  wire logic [IW-1:0]                       act_idx_in,
    input  wire logic [IW-1:0]                       nxt_idx_in,
    input  wire logic signed [cist_pkg::TIME_W-1:0]  best_in,
    output cist_pkg::tok_flags_t                     flags_out,
    output logic [IW-1:0]                            act_idx_out,
    output logic [IW-1:0]                            nxt_idx_out,
    output logic signed [cist_pkg::TIME_W-1:0]       best_out
);

    logic signed [cist_pkg::TIME_W-1:0] start_reg;
    logic signed [cist_pkg::TIME_W-1:0] end_reg;

    cist_pkg::tok_flags_t               flags_reg;
    cist_pkg::tok_flags_t               flags_next;
    logic [IW-1:0]                      act_idx_reg;
    logic [IW-1:0]                      act_idx_next;
    logic [IW-1:0]                      nxt_idx_reg;
    logic [IW-1:0]                      nxt_idx_next;
    logic signed [cist_pkg::TIME_W-1:0] best_reg;
    logic signed [cist_pkg::TIME_W-1:0] best_next;

    logic hit;
    logic cand;

    // held cue
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
        end
    end

    assign hit  = occupied && (start_reg <= qtime) && (qtime < end_reg);
    assign cand = occupied && (start_reg >= qtime)
                  && (!flags_in.nxt_found || (start_reg < best_in));

    always_comb
    begin
        flags_next   = flags_in;
        act_idx_next = act_idx_in;
        nxt_idx_next = nxt_idx_in;
        best_next    = best_in;
        // first covering cue wins
        if (!flags_in.act_found && hit)
        begin
            flags_next.act_found = 1'b1;
            act_idx_next         = IW'(IDX);
        end
        // strictly earlier start replaces, so ties keep the lower index
        if (cand)
        begin
            flags_next.nxt_found = 1'b1;
            nxt_idx_next         = IW'(IDX);
            best_next            = start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_idx_reg <= act_idx_next;
        nxt_idx_reg <= nxt_idx_next;
        best_reg    <= best_next;
    end

    assign flags_out   = flags_reg;
    assign act_idx_out = act_idx_reg;
    assign nxt_idx_out = nxt_idx_reg;
    assign best_out    = best_reg;

endmodule

`default_nettype wire

// ----- src/cist_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module cist_checker #(
    parameter int CAPACITY = cist_pkg::CAPACITY_DEFAULT
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic [cist_pkg::MODE_W-1:0]         mode,
    input wire logic                                done,
    input wire logic                                active_found,
    input wire logic                                next_found,
    input wire logic                                full_error,
    input wire logic [cist_pkg::COUNT_W-1:0]        entry_count
);

    logic take_other;
    logic take_query;

    assign take_other = start && !busy && (mode != cist_pkg::MODE_QUERY);
    assign take_query = start && !busy && (mode == cist_pkg::MODE_QUERY);

    // a non-query item answers on the very next cycle
    `CIST_ASSERT_NEXT(a_other_done, clk, rst_n, take_other, done && !busy, "non-query item lost")

    // a query holds the block until its item is out
    `CIST_ASSERT_NEXT(a_query_busy, clk, rst_n, take_query, busy && !done, "query not held")

    // the end of a query always brings its item
    `CIST_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done, "query ended without item")

    // a rejected append reports a full table and no lookup
    `CIST_ASSERT_NOW(a_full, clk, rst_n, done && full_error, !active_found && !next_found && (entry_count == cist_pkg::COUNT_W'(CAPACITY)), "full flag inconsistent")

endmodule

bind cue_interval_search_table_top cist_checker #(.CAPACITY(CAPACITY)) u_cist_checker (.*);

`default_nettype wire

// ----- dv/tb_cue_interval_search_table_top.sv -----
`timescale 1ns / 1ps

module tb_cue_interval_search_table_top;

    localparam int CAP = cist_pkg::CAPACITY_DEFAULT;

    // the package names three modes only, the fourth code does nothing
    localparam logic [cist_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [cist_pkg::TIME_W-1:0] T_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [cist_pkg::TIME_W-1:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;

    // one result item, in port order
    typedef struct packed {
        logic                         act_found;
        logic [cist_pkg::INDEX_W-1:0] act_idx;
        logic                         nxt_found;
        logic [cist_pkg::INDEX_W-1:0] nxt_idx;
        logic                         full_err;
        logic [cist_pkg::COUNT_W-1:0] count;
    } result_t;

    // a row of the directed table either sends one item or fills the table
    typedef enum logic {ROW_ITEM, ROW_FILL} row_kind_t;

    typedef struct packed {
        row_kind_t                           kind;
        logic [cist_pkg::MODE_W-1:0]         op;
        logic signed [cist_pkg::TIME_W-1:0]  cs;
        logic signed [cist_pkg::TIME_W-1:0]  ce;
        logic signed [cist_pkg::TIME_W-1:0]  qt;
        logic                                pinned;
        result_t                             want;
    } row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [cist_pkg::MODE_W-1:0]         mode;
    logic signed [cist_pkg::TIME_W-1:0]  cue_start;
    logic signed [cist_pkg::TIME_W-1:0]  cue_end;
    logic signed [cist_pkg::TIME_W-1:0]  query_time;
    logic                                done;
    logic                                active_found;
    logic [cist_pkg::INDEX_W-1:0]        active_index;
    logic                                next_found;
    logic [cist_pkg::INDEX_W-1:0]        next_index;
    logic                                full_error;
    logic [cist_pkg::COUNT_W-1:0]        entry_count;

    // typed-in expectation travelling alongside the item being offered
    logic                                pin_valid;
    result_t                             pin_result;

    // our own copy of the cue table
    logic signed [cist_pkg::TIME_W-1:0]  cue_starts [CAP];
    logic signed [cist_pkg::TIME_W-1:0]  cue_ends [CAP];
    int                                  held_cues = 0;

    result_t                             pending_results [$];
    int                                  fail_cnt = 0;
    int                                  gap_pct = 0;
    row_t                                directed_plan [0:25];

    cue_interval_search_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .cue_start    (cue_start),
        .cue_end      (cue_end),
        .query_time   (query_time),
        .done         (done),
        .active_found (active_found),
        .active_index (active_index),
        .next_found   (next_found),
        .next_index   (next_index),
        .full_error   (full_error),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // what the table does with one item: updates our copy and gives the result
    function automatic result_t cue_table_step(input logic [cist_pkg::MODE_W-1:0] op,
                                               input logic signed [cist_pkg::TIME_W-1:0] cs,
                                               input logic signed [cist_pkg::TIME_W-1:0] ce,
                                               input logic signed [cist_pkg::TIME_W-1:0] qt);
        result_t                            r;
        logic signed [cist_pkg::TIME_W-1:0] best;
        int                                 i;
        r = '0;
        best = '0;
        case (op)
            cist_pkg::MODE_APPEND:
            begin
                if (held_cues < CAP)
                begin
                    cue_starts[held_cues] = cs;
                    cue_ends[held_cues] = ce;
                    held_cues++;
                end
                else
                begin
                    r.full_err = 1'b1;
                end
            end
            cist_pkg::MODE_CLEAR:
            begin
                held_cues = 0;
            end
            cist_pkg::MODE_QUERY:
            begin
                for (i = 0; i < held_cues; i++)
                begin
                    // half-open interval, so an empty or reversed cue never covers
                    if (!r.act_found && cue_starts[i] <= qt && qt < cue_ends[i])
                    begin
                        r.act_found = 1'b1;
                        r.act_idx = cist_pkg::INDEX_W'(i);
                    end
                    // strict less-than keeps the lowest index on equal starts
                    if (cue_starts[i] >= qt && (!r.nxt_found || cue_starts[i] < best))
                    begin
                        r.nxt_found = 1'b1;
                        r.nxt_idx = cist_pkg::INDEX_W'(i);
                        best = cue_starts[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = cist_pkg::COUNT_W'(held_cues);
        return r;
    endfunction

    function automatic result_t only_count(input logic [cist_pkg::COUNT_W-1:0] n);
        result_t r;
        r = '0;
        r.count = n;
        return r;
    endfunction

    function automatic logic signed [cist_pkg::TIME_W-1:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    // mostly a few ticks either side of the base, now and then anywhere or an extreme
    function automatic logic signed [cist_pkg::TIME_W-1:0] time_near(
        input logic signed [cist_pkg::TIME_W-1:0] base);
        int                                 pick;
        int                                 off;
        logic signed [cist_pkg::TIME_W-1:0] off64;
        pick = $urandom_range(99);
        off = $urandom_range(60);
        off = off - 30;
        off64 = off;
        if (pick < 8)
            return rand_wide();
        if (pick < 15)
        begin
            case ($urandom_range(3))
                0:       return T_MIN;
                1:       return T_MAX;
                2:       return '0;
                default: return -64'sd1;
            endcase
        end
        return base + off64;
    endfunction

    // end tick for a cue, including empty and reversed intervals
    function automatic logic signed [cist_pkg::TIME_W-1:0] cue_end_for(
        input logic signed [cist_pkg::TIME_W-1:0] cs);
        int                                 off;
        logic signed [cist_pkg::TIME_W-1:0] off64;
        off = $urandom_range(48);
        off = off - 8;
        off64 = off;
        if ($urandom_range(9) == 0)
            return rand_wide();
        return cs + off64;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // offer one item, with random gaps ahead of it, and wait until it is taken
    task automatic send_op(input logic [cist_pkg::MODE_W-1:0] op,
                           input logic signed [cist_pkg::TIME_W-1:0] cs,
                           input logic signed [cist_pkg::TIME_W-1:0] ce,
                           input logic signed [cist_pkg::TIME_W-1:0] qt,
                           input logic pin,
                           input result_t pin_res);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= op;
        cue_start  <= cs;
        cue_end    <= ce;
        query_time <= qt;
        pin_valid  <= pin;
        pin_result <= pin_res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold the sender back until every outstanding result has come
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // episodes: mostly a clear first, then load a batch of cues around one base time and query around it
    task automatic run_random(input int quota);
        int                                 issued;
        int                                 fill;
        int                                 r;
        logic signed [cist_pkg::TIME_W-1:0] base;
        logic signed [cist_pkg::TIME_W-1:0] cs;
        issued = 0;
        while (issued < quota)
        begin
            base = rand_wide();
            if ($urandom_range(4) != 0)
            begin
                send_op(cist_pkg::MODE_CLEAR, rand_wide(), rand_wide(), rand_wide(), 1'b0, '0);
                issued++;
            end
            // now and then load a batch of three below capacity to two past it
            fill = ($urandom_range(7) == 0) ? CAP - 3 + $urandom_range(5)
                                            : $urandom_range(12, 1);
            repeat (fill)
            begin
                cs = time_near(base);
                send_op(cist_pkg::MODE_APPEND, cs, cue_end_for(cs), rand_wide(), 1'b0, '0);
                issued++;
                if ($urandom_range(3) == 0)
                begin
                    send_op(cist_pkg::MODE_QUERY, rand_wide(), rand_wide(), time_near(base),
                            1'b0, '0);
                    issued++;
                end
            end
            repeat ($urandom_range(8, 2))
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    send_op(cist_pkg::MODE_QUERY, rand_wide(), rand_wide(), time_near(base),
                            1'b0, '0);
                    issued++;
                end
                else if (r < 85)
                begin
                    cs = time_near(base);
                    send_op(cist_pkg::MODE_APPEND, cs, cue_end_for(cs), rand_wide(), 1'b0, '0);
                    issued++;
                end
                else if (r < 92)
                begin
                    send_op(cist_pkg::MODE_CLEAR, rand_wide(), rand_wide(), rand_wide(),
                            1'b0, '0);
                    issued++;
                end
                else
                begin
                    // unused code: ignored by the block, not counted
                    send_op(MODE_UNUSED, rand_wide(), rand_wide(), rand_wide(), 1'b0, '0);
                end
            end
        end
    endtask

    // result checking and prediction, both on the same edge as the handshake
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{active_found, active_index, next_found, next_index,
                        full_error, entry_count};
                if (pending_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("active_found", want.act_found, got.act_found);
                    check_field("active_index", want.act_idx, got.act_idx);
                    check_field("next_found", want.nxt_found, got.nxt_found);
                    check_field("next_index", want.nxt_idx, got.nxt_idx);
                    check_field("full_error", want.full_err, got.full_err);
                    check_field("entry_count", want.count, got.count);
                end
            end
            // the predictor always runs so our table copy stays in step
            if (start && !busy)
            begin
                pred = cue_table_step(mode, cue_start, cue_end, query_time);
                pending_results.insert(pending_results.size(), pin_valid ? pin_result : pred);
            end
        end
    end

    initial
    begin : stimulus
        int                                 k;
        int                                 phase;
        int                                 phase_gaps [4];
        logic signed [cist_pkg::TIME_W-1:0] base;
        logic signed [cist_pkg::TIME_W-1:0] cs;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        mode       <= cist_pkg::MODE_APPEND;
        cue_start  <= '0;
        cue_end    <= '0;
        query_time <= '0;
        pin_valid  <= 1'b0;
        pin_result <= '0;

        // directed rows: typed-in results where obvious, predictor elsewhere
        directed_plan = '{
            // empty table after reset
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, 64'sd0, 1'b1,
              only_count(7'd0)},
            '{ROW_ITEM, MODE_UNUSED, T_MAX,  T_MIN,  T_MIN,  1'b1, only_count(7'd0)},
            // one cue spanning the whole time line, probed at both ends
            '{ROW_ITEM, cist_pkg::MODE_APPEND, T_MIN,  T_MAX,  64'sd0, 1'b1,
              only_count(7'd1)},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, T_MIN,  1'b1,
              result_t'{1'b1, 6'd0, 1'b1, 6'd0, 1'b0, 7'd1}},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, T_MAX,  1'b1,
              only_count(7'd1)},
            // empty and reversed cues
            '{ROW_ITEM, cist_pkg::MODE_APPEND, 64'sd5, 64'sd5, 64'sd0, 1'b1,
              only_count(7'd2)},
            '{ROW_ITEM, cist_pkg::MODE_APPEND, 64'sd10, 64'sd3, 64'sd0, 1'b1,
              only_count(7'd3)},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, 64'sd5, 1'b0, '0},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, -64'sd1, 1'b0, '0},
            '{ROW_ITEM, cist_pkg::MODE_APPEND, T_MAX,  T_MAX,  64'sd0, 1'b1,
              only_count(7'd4)},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, T_MAX,  1'b0, '0},
            // equal starts, lowest index must win the next-cue lookup
            '{ROW_ITEM, cist_pkg::MODE_APPEND, -64'sd20, 64'sd0, 64'sd0, 1'b1,
              only_count(7'd5)},
            '{ROW_ITEM, cist_pkg::MODE_APPEND, -64'sd20, 64'sd100, 64'sd0, 1'b1,
              only_count(7'd6)},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, -64'sd20, 1'b0, '0},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, 64'sd3, 1'b0, '0},
            '{ROW_ITEM, MODE_UNUSED, -64'sd1, -64'sd1, -64'sd1, 1'b0, '0},
            // clear, then a single unit cue
            '{ROW_ITEM, cist_pkg::MODE_CLEAR,  -64'sd1, -64'sd1, -64'sd1, 1'b1,
              only_count(7'd0)},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, 64'sd0, 1'b1,
              only_count(7'd0)},
            '{ROW_ITEM, cist_pkg::MODE_APPEND, 64'sd0, 64'sd1, 64'sd0, 1'b1,
              only_count(7'd1)},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, 64'sd0, 1'b1,
              result_t'{1'b1, 6'd0, 1'b1, 6'd0, 1'b0, 7'd1}},
            '{ROW_ITEM, cist_pkg::MODE_CLEAR,  64'sd0, 64'sd0, 64'sd0, 1'b1,
              only_count(7'd0)},
            // full table: the extra append is dropped and flagged
            '{ROW_FILL, cist_pkg::MODE_APPEND, 64'sd0, 64'sd0, 64'sd0, 1'b0, '0},
            '{ROW_ITEM, cist_pkg::MODE_APPEND, T_MIN,  T_MAX,  64'sd0, 1'b1,
              result_t'{1'b0, 6'd0, 1'b0, 6'd0, 1'b1, 7'd64}},
            '{ROW_ITEM, cist_pkg::MODE_QUERY,  64'sd0, 64'sd0, T_MIN,  1'b0, '0},
            '{ROW_ITEM, MODE_UNUSED, T_MIN,  T_MIN,  T_MAX,  1'b1, only_count(7'd64)},
            '{ROW_ITEM, cist_pkg::MODE_CLEAR,  T_MAX,  T_MAX,  T_MAX,  1'b1,
              only_count(7'd0)}
        };
        phase_gaps = '{0, 79, 0, 22};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no gaps
        gap_pct = 0;
        for (k = 0; k < 26; k++)
        begin
            if (directed_plan[k].kind == ROW_FILL)
            begin
                base = rand_wide();
                repeat (CAP)
                begin
                    cs = time_near(base);
                    send_op(cist_pkg::MODE_APPEND, cs, cue_end_for(cs), rand_wide(), 1'b0, '0);
                end
            end
            else
            begin
                send_op(directed_plan[k].op, directed_plan[k].cs, directed_plan[k].ce,
                        directed_plan[k].qt, directed_plan[k].pinned,
                        directed_plan[k].want);
            end
        end
        wait_for_results();

        // random phases, each drained before the next so the sender pauses fully
        for (phase = 0; phase < 4; phase++)
        begin
            gap_pct = phase_gaps[phase];
            run_random(150);
            wait_for_results();
        end

        // room for a stray result after the last one expected
        repeat (CAP + 4) @(posedge clk);
        if (fail_cnt == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
